>>> hw/rtl/fbih_pkg.sv
// Shared types and constants of the firmware block to Intel HEX encoder.
`default_nettype none
package fbih_pkg;

   localparam int unsigned LIMIT_W = 17;
   localparam logic [LIMIT_W-1:0] LIMIT_RESET = 17'h04000;

   // job kinds passed from parser to emitter
   localparam logic [2:0] JOB_HEADER   = 3'd0;
   localparam logic [2:0] JOB_DATA     = 3'd1;
   localparam logic [2:0] JOB_EOF      = 3'd2;
   localparam logic [2:0] JOB_TRUNC    = 3'd3;
   localparam logic [2:0] JOB_OVERSIZE = 3'd4;

   localparam logic [1:0] ERR_NONE   = 2'd0;
   localparam logic [1:0] ERR_TRUNC  = 2'd1;
   localparam logic [1:0] ERR_LENGTH = 2'd2;

   localparam logic [6:0] CHAR_COLON   = 7'h3A;
   localparam logic [6:0] CHAR_ZERO    = 7'h30;
   localparam logic [6:0] CHAR_ONE     = 7'h31;
   localparam logic [6:0] CHAR_F       = 7'h46;
   localparam logic [6:0] CHAR_NEWLINE = 7'h0A;
   localparam logic [6:0] CHAR_NUL     = 7'h00;

   typedef struct packed {
      logic       command;
      logic [7:0] data_byte;
   } req_payload_type;

   typedef struct packed {
      logic [6:0] text_char;
      logic       last_of_run;
      logic [1:0] error_code;
   } rsp_payload_type;

   typedef logic [LIMIT_W-1:0] csr_payload_type;

   typedef struct packed {
      logic [2:0]  kind;
      logic [7:0]  value;
      logic [15:0] addr;
      logic [7:0]  check;
      logic        tail;
   } job_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

endpackage
`default_nettype wire

>>> hw/rtl/fbih_chan_if.sv
// Valid/ready channel interface carrying one payload beat.
`default_nettype none
interface fbih_chan_if #(parameter type payload_type = logic) ();
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface
`default_nettype wire

>>> hw/rtl/firmware_blocks_to_intel_hex.sv
// Firmware block stream to Intel HEX text encoder, top level.
//
// req_chan carries one stream beat per handshake: command 0 with a data byte,
// or command 1 to end the stream. rsp_chan carries one ASCII character beat
// per handshake, with last_of_run on the final beat an input caused and
// error_code on error beats (text_char 0). csr_chan writes address_limit; it
// is always ready and must only be written while the block is idle.
// A parser accepts beats and queues emit jobs; an emitter expands each job
// into characters, one beat per cycle while jobs wait and the receiver takes
// them, through a registered output. An input's first character passes
// through the job queue and then the output register. A content byte gives
// two characters (five for the last byte of a record), a record header nine
// (twelve for an empty block), the end-of-file record twelve, an error one
// beat; other header bytes give no output.
// Reset clears the parse state and the job queue and sets address_limit to
// 0x4000. When the receiver stalls, the output beat holds, the job queue
// (QUEUE_DEPTH entries) fills, and req_chan.ready drops once it is full.
`default_nettype none
module firmware_blocks_to_intel_hex #(
   parameter int unsigned QUEUE_DEPTH = 4
) (
   input wire logic    clock,
   input wire logic    reset,
   fbih_chan_if.sink   req_chan,
   fbih_chan_if.source rsp_chan,
   fbih_chan_if.sink   csr_chan
);

   fbih_pkg::job_type          push_job;
   logic                       push_valid;
   fbih_pkg::job_type          head_job;
   fbih_pkg::queue_status_type status;
   logic                       pop;
   logic                       req_accept;

   assign req_chan.ready = !status.full;
   assign csr_chan.ready = 1'b1;
   assign req_accept     = req_chan.valid && !status.full;

   fbih_front u_front (
      .clock      (clock),
      .reset      (reset),
      .in_accept  (req_accept),
      .in_item    (req_chan.payload),
      .csr_write  (csr_chan.valid),
      .csr_value  (csr_chan.payload),
      .push_job   (push_job),
      .push_valid (push_valid)
   );

   fbih_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push_valid),
      .push_job (push_job),
      .pop      (pop),
      .head_job (head_job),
      .status   (status)
   );

   fbih_back u_back (
      .clock     (clock),
      .reset     (reset),
      .head_job  (head_job),
      .status    (status),
      .pop       (pop),
      .out_valid (rsp_chan.valid),
      .out_beat  (rsp_chan.payload),
      .out_ready (rsp_chan.ready)
   );

endmodule
`default_nettype wire

>>> hw/rtl/fbih_front.sv
// Block stream parser: tracks header and content, issues emit jobs.
`default_nettype none
module fbih_front (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     in_accept,
   input  wire fbih_pkg::req_payload_type in_item,
   input  wire logic                     csr_write,
   input  wire fbih_pkg::csr_payload_type csr_value,
   output fbih_pkg::job_type             push_job,
   output logic                          push_valid
);

   logic [1:0]                hpos_ff, hpos_in;
   logic [15:0]               addr_ff, addr_in;
   logic [15:0]               rem_ff, rem_in;
   logic [7:0]                sum_ff, sum_in;
   logic                      skip_ff, skip_in;
   fbih_pkg::csr_payload_type limit_ff, limit_in;

   logic [15:0] rem_dec;
   logic [15:0] len_full;
   logic [7:0]  sum_data;
   logic [7:0]  sum_head;

   assign rem_dec  = rem_ff - 16'd1;
   assign len_full = {rem_ff[15:8], in_item.data_byte};
   assign sum_data = sum_ff + in_item.data_byte;
   assign sum_head = in_item.data_byte + addr_ff[15:8] + addr_ff[7:0];
   assign limit_in = csr_write ? csr_value : limit_ff;

   always_comb begin
      hpos_in    = hpos_ff;
      addr_in    = addr_ff;
      rem_in     = rem_ff;
      sum_in     = sum_ff;
      skip_in    = skip_ff;
      push_valid = 1'b0;
      push_job   = '0;
      if (in_accept) begin
         if (in_item.command) begin
            push_valid = 1'b1;
            if (hpos_ff != 2'd0 || rem_ff != 16'd0) begin
               push_job.kind = fbih_pkg::JOB_TRUNC;
            end else begin
               push_job.kind = fbih_pkg::JOB_EOF;
            end
            hpos_in = 2'd0;
            addr_in = '0;
            rem_in  = '0;
            sum_in  = '0;
            skip_in = 1'b0;
         end else if (hpos_ff == 2'd0 && rem_ff != 16'd0) begin
            rem_in = rem_dec;
            if (!skip_ff) begin
               sum_in          = sum_data;
               push_valid      = 1'b1;
               push_job.kind   = fbih_pkg::JOB_DATA;
               push_job.value  = in_item.data_byte;
               push_job.check  = 8'd0 - sum_data;
               push_job.tail   = (rem_dec == 16'd0);
            end
            if (rem_dec == 16'd0) begin
               skip_in = 1'b0;
            end
         end else begin
            case (hpos_ff)
               2'd0: begin
                  addr_in = {in_item.data_byte, 8'd0};
                  hpos_in = 2'd1;
               end
               2'd1: begin
                  addr_in = {addr_ff[15:8], in_item.data_byte};
                  hpos_in = 2'd2;
               end
               2'd2: begin
                  rem_in  = {in_item.data_byte, 8'd0};
                  hpos_in = 2'd3;
               end
               default: begin
                  rem_in  = len_full;
                  hpos_in = 2'd0;
                  if ({1'b0, addr_ff} >= limit_ff) begin
                     skip_in = (len_full != 16'd0);
                  end else if (len_full[15:8] != 8'd0) begin
                     skip_in       = 1'b1;
                     push_valid    = 1'b1;
                     push_job.kind = fbih_pkg::JOB_OVERSIZE;
                  end else begin
                     skip_in        = 1'b0;
                     sum_in         = sum_head;
                     push_valid     = 1'b1;
                     push_job.kind  = fbih_pkg::JOB_HEADER;
                     push_job.value = in_item.data_byte;
                     push_job.addr  = addr_ff;
                     push_job.check = 8'd0 - sum_head;
                     push_job.tail  = (in_item.data_byte == 8'd0);
                  end
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hpos_ff  <= '0;
         addr_ff  <= '0;
         rem_ff   <= '0;
         sum_ff   <= '0;
         skip_ff  <= 1'b0;
         limit_ff <= fbih_pkg::LIMIT_RESET;
      end else begin
         hpos_ff  <= hpos_in;
         addr_ff  <= addr_in;
         rem_ff   <= rem_in;
         sum_ff   <= sum_in;
         skip_ff  <= skip_in;
         limit_ff <= limit_in;
      end
   end

endmodule
`default_nettype wire

>>> hw/rtl/fbih_queue.sv
// Short job queue between parser and emitter.
`default_nettype none
module fbih_queue #(
   parameter int unsigned DEPTH = 4
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      push,
   input  wire fbih_pkg::job_type         push_job,
   input  wire logic                      pop,
   output fbih_pkg::job_type              head_job,
   output fbih_pkg::queue_status_type     status
);

   localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);

   fbih_pkg::job_type slot_ff [DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic              do_push;
   logic              do_pop;

   assign status.full  = (count_ff == CNT_W'(DEPTH));
   assign status.empty = (count_ff == '0);
   assign do_push      = push && !status.full;
   assign do_pop       = pop && !status.empty;
   assign head_job     = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_job;
      end
   end

endmodule
`default_nettype wire

>>> hw/rtl/fbih_back.sv
// Record emitter: turns queued jobs into one ASCII character beat per cycle while the output is not stalled.
`default_nettype none
module fbih_back (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire fbih_pkg::job_type         head_job,
   input  wire fbih_pkg::queue_status_type status,
   output logic                           pop,
   output logic                           out_valid,
   output fbih_pkg::rsp_payload_type      out_beat,
   input  wire logic                      out_ready
);

   logic [3:0]                pos_ff, pos_in;
   logic                      valid_ff, valid_in;
   fbih_pkg::rsp_payload_type beat_ff, beat_in;
   logic                      out_free;
   logic                      last;
   logic [6:0]                ch;
   logic [1:0]                err;

   function automatic logic [6:0] hex_char(input logic [3:0] v);
      if (v < 4'd10) begin
         hex_char = 7'h30 + {3'd0, v};
      end else begin
         hex_char = 7'h37 + {3'd0, v};
      end
   endfunction

   function automatic logic [6:0] tail_char(input logic [7:0] chk, input logic [1:0] idx);
      case (idx)
         2'd0:    tail_char = hex_char(chk[7:4]);
         2'd1:    tail_char = hex_char(chk[3:0]);
         default: tail_char = fbih_pkg::CHAR_NEWLINE;
      endcase
   endfunction

   always_comb begin
      ch   = fbih_pkg::CHAR_NUL;
      err  = fbih_pkg::ERR_NONE;
      last = 1'b0;
      case (head_job.kind)
         fbih_pkg::JOB_HEADER: begin
            case (pos_ff)
               4'd0:    ch = fbih_pkg::CHAR_COLON;
               4'd1:    ch = hex_char(head_job.value[7:4]);
               4'd2:    ch = hex_char(head_job.value[3:0]);
               4'd3:    ch = hex_char(head_job.addr[15:12]);
               4'd4:    ch = hex_char(head_job.addr[11:8]);
               4'd5:    ch = hex_char(head_job.addr[7:4]);
               4'd6:    ch = hex_char(head_job.addr[3:0]);
               4'd7:    ch = fbih_pkg::CHAR_ZERO;
               4'd8:    ch = fbih_pkg::CHAR_ZERO;
               4'd9:    ch = tail_char(head_job.check, 2'd0);
               4'd10:   ch = tail_char(head_job.check, 2'd1);
               default: ch = tail_char(head_job.check, 2'd2);
            endcase
            last = head_job.tail ? (pos_ff == 4'd11) : (pos_ff == 4'd8);
         end
         fbih_pkg::JOB_DATA: begin
            case (pos_ff)
               4'd0:    ch = hex_char(head_job.value[7:4]);
               4'd1:    ch = hex_char(head_job.value[3:0]);
               4'd2:    ch = tail_char(head_job.check, 2'd0);
               4'd3:    ch = tail_char(head_job.check, 2'd1);
               default: ch = tail_char(head_job.check, 2'd2);
            endcase
            last = head_job.tail ? (pos_ff == 4'd4) : (pos_ff == 4'd1);
         end
         fbih_pkg::JOB_EOF: begin
            case (pos_ff)
               4'd0:    ch = fbih_pkg::CHAR_COLON;
               4'd8:    ch = fbih_pkg::CHAR_ONE;
               4'd9:    ch = fbih_pkg::CHAR_F;
               4'd10:   ch = fbih_pkg::CHAR_F;
               4'd11:   ch = fbih_pkg::CHAR_NEWLINE;
               default: ch = fbih_pkg::CHAR_ZERO;
            endcase
            // colon, seven zeros, one, two F and newline: positions 0 to 11 then stop
            last = (pos_ff == 4'd11);
         end
         fbih_pkg::JOB_TRUNC: begin
            err  = fbih_pkg::ERR_TRUNC;
            last = 1'b1;
         end
         default: begin
            err  = fbih_pkg::ERR_LENGTH;
            last = 1'b1;
         end
      endcase
   end

   assign out_free  = !valid_ff || out_ready;
   assign pop       = out_free && !status.empty && last;
   assign out_valid = valid_ff;
   assign out_beat  = beat_ff;

   always_comb begin
      pos_in   = pos_ff;
      valid_in = valid_ff;
      beat_in  = beat_ff;
      if (out_free) begin
         valid_in = !status.empty;
         if (!status.empty) begin
            beat_in.text_char   = ch;
            beat_in.last_of_run = last;
            beat_in.error_code  = err;
            pos_in              = last ? 4'd0 : pos_ff + 4'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff   <= '0;
         valid_ff <= 1'b0;
      end else begin
         pos_ff   <= pos_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      beat_ff <= beat_in;
   end

endmodule
`default_nettype wire

>>> hw/rtl/fbih_checker.sv
// Port-level checks of the encoder, bound to the top level.
`default_nettype none
module fbih_checker (
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       rsp_valid,
   input wire logic       rsp_ready,
   input wire logic [6:0] rsp_text_char,
   input wire logic       rsp_last_of_run,
   input wire logic [1:0] rsp_error_code,
   input wire logic       csr_ready
);

   // hold a stalled beat
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_text_char)
         && $stable(rsp_last_of_run) && $stable(rsp_error_code))
      else $error("rsp beat changed while stalled");

   a_err_beat: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_error_code != fbih_pkg::ERR_NONE
         |-> rsp_last_of_run && rsp_text_char == fbih_pkg::CHAR_NUL)
      else $error("error beat is not a lone nul beat");

   a_text_beat: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_error_code == fbih_pkg::ERR_NONE
         |-> rsp_text_char != fbih_pkg::CHAR_NUL)
      else $error("text beat carries nul");

   a_reset_idle: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("rsp valid right after reset");

   a_csr_ready: assert property (@(posedge clock) disable iff (reset)
      csr_ready)
      else $error("register port not ready");

endmodule

bind firmware_blocks_to_intel_hex fbih_checker u_fbih_checker (
   .clock           (clock),
   .reset           (reset),
   .rsp_valid       (rsp_chan.valid),
   .rsp_ready       (rsp_chan.ready),
   .rsp_text_char   (rsp_chan.payload.text_char),
   .rsp_last_of_run (rsp_chan.payload.last_of_run),
   .rsp_error_code  (rsp_chan.payload.error_code),
   .csr_ready       (csr_chan.ready)
);
`default_nettype wire
